@@ design/assert_macros.svh @@
// Assertion helpers for the console engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on i_clk, off while in reset
`define TCCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked on i_clk, also checked during reset
`define TCCE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/tcce_pkg.sv @@
package tcce_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NL       = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SP       = 8'h20;
    localparam logic [7:0]        RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;

    typedef enum logic [1:0] {
        CMD_PUT        = 2'd0,
        CMD_CLR_SCREEN = 2'd1,
        CMD_CLR_ROW    = 2'd2,
        CMD_READ       = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_PUTC,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_CLR_SCREEN,
        OP_CLR_ROW,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] raddr;
        logic              rd_ok;
    } t_entry;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_READ,
        ST_PREV,
        ST_RES
    } t_state;

    function automatic logic [ADDR_W-1:0] lin_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLS);
        return base + ADDR_W'(col);
    endfunction

endpackage

@@ design/tcce_if.sv @@
interface tcce_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;

    modport source (output valid, output cmd, output char_code, output read_col,
                    output read_row, input ready);
    modport sink   (input valid, input cmd, input char_code, input read_col,
                    input read_row, output ready);
endinterface

interface tcce_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [7:0]  prev_char;
    logic [15:0] cell_value;
    logic        scrolled;

    modport source (output valid, output cursor_col, output cursor_row,
                    output prev_char, output cell_value, output scrolled, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input prev_char, input cell_value, input scrolled, output ready);
endinterface

@@ design/tcce_front.sv @@
module tcce_front (
    tcce_in_if.sink               i_in,
    input  logic                  i_enable,
    input  tcce_pkg::t_q_status   i_q_status,
    output logic                  o_push,
    output tcce_pkg::t_entry      o_entry
);

    assign i_in.ready = i_enable && !i_q_status.full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_entry.ch    = i_in.char_code;
        o_entry.raddr = tcce_pkg::lin_addr(i_in.read_row, i_in.read_col);
        o_entry.rd_ok = (i_in.read_col < tcce_pkg::COL_W'(tcce_pkg::COLS)) &&
                        (i_in.read_row < tcce_pkg::ROW_W'(tcce_pkg::ROWS));
        unique case (tcce_pkg::t_cmd'(i_in.cmd))
            tcce_pkg::CMD_PUT: begin
                priority if (i_in.char_code == tcce_pkg::CH_NL) begin
                    o_entry.op = tcce_pkg::OP_NEWLINE;
                end else if (i_in.char_code == tcce_pkg::CH_CR) begin
                    o_entry.op = tcce_pkg::OP_RETURN;
                end else if (i_in.char_code == tcce_pkg::CH_BS) begin
                    o_entry.op = tcce_pkg::OP_BACKSPACE;
                end else begin
                    o_entry.op = tcce_pkg::OP_PUTC;
                end
            end
            tcce_pkg::CMD_CLR_SCREEN: o_entry.op = tcce_pkg::OP_CLR_SCREEN;
            tcce_pkg::CMD_CLR_ROW:    o_entry.op = tcce_pkg::OP_CLR_ROW;
            tcce_pkg::CMD_READ:       o_entry.op = tcce_pkg::OP_READ;
        endcase
    end

endmodule

@@ design/tcce_queue.sv @@
module tcce_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tcce_pkg::t_entry      i_entry,
    input  logic                  i_pop,
    output tcce_pkg::t_entry      o_entry,
    output tcce_pkg::t_q_status   o_status
);

    tcce_pkg::t_entry                r_slot [tcce_pkg::QDEPTH];
    logic [tcce_pkg::QPTR_W-1:0]     r_wp;
    logic [tcce_pkg::QPTR_W-1:0]     r_rp;
    logic [tcce_pkg::QCNT_W-1:0]     r_cnt;

    localparam logic [tcce_pkg::QPTR_W-1:0] PTR_LAST =
        tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1);

    assign o_entry        = r_slot[r_rp];
    assign o_status.count = r_cnt;
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == tcce_pkg::QCNT_W'(tcce_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + tcce_pkg::QCNT_W'(i_push) - tcce_pkg::QCNT_W'(i_pop);
        end
    end

endmodule

@@ design/tcce_back.sv @@
module tcce_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata,
    input  tcce_pkg::t_entry      i_entry,
    input  tcce_pkg::t_q_status   i_q_status,
    output logic                  o_pop,
    output logic                  o_init_done,
    tcce_out_if.source            o_out
);

    localparam int AW = tcce_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_CELL  = AW'(tcce_pkg::CELLS - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(tcce_pkg::CELLS - tcce_pkg::COLS);
    localparam logic [AW-1:0] ROW_SPAN   = AW'(tcce_pkg::COLS);
    localparam logic [tcce_pkg::COL_W-1:0] COL_LAST = tcce_pkg::COL_W'(tcce_pkg::COLS - 1);
    localparam logic [tcce_pkg::ROW_W-1:0] ROW_LAST = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);

    tcce_pkg::t_state               r_state, n_state;
    logic [tcce_pkg::COL_W-1:0]     r_col, n_col;
    logic [tcce_pkg::ROW_W-1:0]     r_row, n_row;
    logic [AW-1:0]                  r_addr, n_addr;
    logic [AW-1:0]                  r_end, n_end;
    logic [AW-1:0]                  r_wdst, n_wdst;
    logic                           r_wpend, n_wpend;
    logic [tcce_pkg::CELL_W-1:0]    r_cell, n_cell;
    logic                           r_scrolled, n_scrolled;
    logic [7:0]                     r_color;

    logic [tcce_pkg::CELL_W-1:0]    r_mem [tcce_pkg::CELLS];
    logic [tcce_pkg::CELL_W-1:0]    r_rdata;
    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_waddr, mem_raddr;
    logic [tcce_pkg::CELL_W-1:0]    mem_wdata;

    logic                           r_out_valid;
    logic [tcce_pkg::COL_W-1:0]     r_o_col;
    logic [tcce_pkg::ROW_W-1:0]     r_o_row;
    logic [tcce_pkg::CHAR_W-1:0]    r_o_prev;
    logic [tcce_pkg::CELL_W-1:0]    r_o_cell;
    logic                           r_o_scr;
    logic                           out_load;

    logic                           start;
    logic                           at_origin;
    logic                           col_last;
    logic                           row_last;
    logic [AW-1:0]                  cur_lin;
    logic [AW-1:0]                  row_base;
    logic [tcce_pkg::CELL_W-1:0]    blank;

    assign start     = (r_state == tcce_pkg::ST_IDLE) && !i_q_status.empty && !r_out_valid;
    assign o_pop     = start;
    assign o_init_done = (r_state != tcce_pkg::ST_INIT);
    assign at_origin = (r_col == '0) && (r_row == '0);
    assign col_last  = (r_col == COL_LAST);
    assign row_last  = (r_row == ROW_LAST);
    assign cur_lin   = tcce_pkg::lin_addr(r_row, r_col);
    assign row_base  = tcce_pkg::lin_addr(r_row, '0);
    assign blank     = {r_color, tcce_pkg::CH_SP};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcce_pkg::ST_INIT: begin
                if (r_addr == LAST_CELL) n_state = tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_entry.op)
                        tcce_pkg::OP_PUTC:
                            n_state = (col_last && row_last) ? tcce_pkg::ST_SCROLL
                                                             : tcce_pkg::ST_PREV;
                        tcce_pkg::OP_NEWLINE:
                            n_state = row_last ? tcce_pkg::ST_SCROLL : tcce_pkg::ST_PREV;
                        tcce_pkg::OP_CLR_SCREEN,
                        tcce_pkg::OP_CLR_ROW:
                            n_state = tcce_pkg::ST_FILL;
                        tcce_pkg::OP_READ:
                            n_state = i_entry.rd_ok ? tcce_pkg::ST_READ : tcce_pkg::ST_PREV;
                        default:
                            n_state = tcce_pkg::ST_PREV;
                    endcase
                end
            end
            tcce_pkg::ST_SCROLL: begin
                if (r_addr == SCROLL_END) n_state = tcce_pkg::ST_FILL;
            end
            tcce_pkg::ST_FILL: begin
                if (r_addr == r_end) n_state = tcce_pkg::ST_PREV;
            end
            tcce_pkg::ST_READ: n_state = tcce_pkg::ST_PREV;
            tcce_pkg::ST_PREV: n_state = tcce_pkg::ST_RES;
            tcce_pkg::ST_RES:  n_state = tcce_pkg::ST_IDLE;
            default:           n_state = tcce_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_addr     = r_addr;
        n_end      = r_end;
        n_wdst     = r_wdst;
        n_wpend    = r_wpend;
        n_cell     = r_cell;
        n_scrolled = r_scrolled;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = blank;
        mem_re     = 1'b0;
        mem_raddr  = r_addr;
        out_load   = 1'b0;
        unique case (r_state)
            tcce_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = tcce_pkg::RESET_CELL;
                n_addr    = r_addr + 1'b1;
            end
            tcce_pkg::ST_IDLE: begin
                if (start) begin
                    n_cell     = '0;
                    n_scrolled = 1'b0;
                    n_addr     = '0;
                    n_wpend    = 1'b0;
                    unique case (i_entry.op)
                        tcce_pkg::OP_PUTC: begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_lin;
                            mem_wdata = {r_color, i_entry.ch};
                            if (col_last) begin
                                n_col = '0;
                                if (row_last) begin
                                    n_scrolled = 1'b1;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        tcce_pkg::OP_NEWLINE: begin
                            n_col = '0;
                            if (row_last) begin
                                n_scrolled = 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end
                        tcce_pkg::OP_RETURN: begin
                            n_col = '0;
                        end
                        tcce_pkg::OP_BACKSPACE: begin
                            mem_we    = 1'b1;
                            mem_waddr = at_origin ? '0 : cur_lin - 1'b1;
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end else if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                                n_col = COL_LAST;
                            end
                        end
                        tcce_pkg::OP_CLR_SCREEN: begin
                            n_end = LAST_CELL;
                            n_col = '0;
                            n_row = '0;
                        end
                        tcce_pkg::OP_CLR_ROW: begin
                            n_addr = row_base;
                            n_end  = row_base + ROW_SPAN - 1'b1;
                            n_col  = '0;
                        end
                        tcce_pkg::OP_READ: begin
                            mem_re    = i_entry.rd_ok;
                            mem_raddr = i_entry.raddr;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tcce_pkg::ST_SCROLL: begin
                if (r_wpend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wdst;
                    mem_wdata = r_rdata;
                end
                if (r_addr != SCROLL_END) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr + ROW_SPAN;
                    n_wpend   = 1'b1;
                    n_wdst    = r_addr;
                    n_addr    = r_addr + 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_end   = LAST_CELL;
                end
            end
            tcce_pkg::ST_FILL: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            tcce_pkg::ST_READ: begin
                n_cell = r_rdata;
            end
            tcce_pkg::ST_PREV: begin
                mem_re    = 1'b1;
                mem_raddr = cur_lin - 1'b1;
            end
            tcce_pkg::ST_RES: begin
                out_load = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcce_pkg::ST_INIT;
            r_col      <= '0;
            r_row      <= '0;
            r_addr     <= '0;
            r_end      <= '0;
            r_wpend    <= 1'b0;
            r_scrolled <= 1'b0;
            r_color    <= tcce_pkg::RESET_COLOR;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_addr     <= n_addr;
            r_end      <= n_end;
            r_wpend    <= n_wpend;
            r_scrolled <= n_scrolled;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wdst <= n_wdst;
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_col  <= r_col;
            r_o_row  <= r_row;
            r_o_prev <= at_origin ? tcce_pkg::CH_SP : r_rdata[tcce_pkg::CHAR_W-1:0];
            r_o_cell <= r_cell;
            r_o_scr  <= r_scrolled;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_col = r_o_col;
    assign o_out.cursor_row = r_o_row;
    assign o_out.prev_char  = r_o_prev;
    assign o_out.cell_value = r_o_cell;
    assign o_out.scrolled   = r_o_scr;

endmodule

@@ design/text_console_cursor_engine_unit.sv @@
// Steps: dispatch; a cell read for an in-range read, a scroll or fill where one is needed;
// prev-char read; result load. The result then holds until it is taken.
// A new item is not dispatched until the previous result has been taken (dispatch, prev-char
// read, result load and the result handshake); a two-entry queue buffers the input meanwhile.
// Scroll copies rows up, then fills the last row; clear screen fills every cell; clear row one row.
// Reset: synchronous, active low; a clearing pass blanks the store, no item taken.
`include "assert_macros.svh"

module text_console_cursor_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcce_in_if.sink     i_in,
    tcce_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    tcce_pkg::t_entry     front_entry;
    tcce_pkg::t_entry     q_entry;
    tcce_pkg::t_q_status  q_status;
    logic                 q_push;
    logic                 q_pop;
    logic                 init_done;
    logic                 cursor_ok;

    tcce_front u_front (
        .i_in       (i_in),
        .i_enable   (init_done),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_entry    (front_entry)
    );

    tcce_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (front_entry),
        .i_pop    (q_pop),
        .o_entry  (q_entry),
        .o_status (q_status)
    );

    tcce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_entry     (q_entry),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .o_init_done (init_done),
        .o_out       (o_out)
    );

    assign cursor_ok = (o_out.cursor_col < 7'(tcce_pkg::COLS)) &&
                       (o_out.cursor_row < 5'(tcce_pkg::ROWS));

    `TCCE_ASSERT(a_push_not_full, q_push |-> !q_status.full, "push into full queue")
    `TCCE_ASSERT(a_pop_not_empty, q_pop |-> !q_status.empty, "pop from empty queue")
    `TCCE_ASSERT(a_no_accept_init, !init_done |-> !i_in.ready, "item taken during clear")
    `TCCE_ASSERT(a_cursor_range, o_out.valid |-> cursor_ok, "cursor out of range")
    `TCCE_ASSERT_RST(a_reset_out_idle, !i_rst_n |=> !o_out.valid, "result valid after reset")

endmodule

@@ test/tb_text_console_cursor_engine_unit.sv @@
module tb_text_console_cursor_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 20;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } console_cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] prev;
        logic [CELL_W-1:0] cell_word;
        logic              scrolled;
    } console_view_t;

    typedef struct packed {
        console_cmd_t  op;
        int unsigned   reps;
        logic          typed;
        console_view_t want;
    } script_row_t;

    localparam int SCRIPT_LEN = 24;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{'{CMD_READ, 8'h00, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, RESET_CELL, 1'b0}},
        '{'{CMD_READ, 8'h00, 7'd79, 5'd24}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, RESET_CELL, 1'b0}},
        '{'{CMD_READ, 8'h00, 7'd127, 5'd31}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_READ, 8'h00, 7'd80, 5'd0}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_READ, 8'h00, 7'd0, 5'd25}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_PUT, CH_BS, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_PUT, 8'h41, 7'd0, 5'd0}, 1, 1'b1, '{7'd1, 5'd0, 8'h41, 16'h0000, 1'b0}},
        '{'{CMD_PUT, 8'h00, 7'd127, 5'd31}, 1, 1'b1, '{7'd2, 5'd0, 8'h00, 16'h0000, 1'b0}},
        '{'{CMD_PUT, 8'hFF, 7'd0, 5'd0}, 1, 1'b1, '{7'd3, 5'd0, 8'hFF, 16'h0000, 1'b0}},
        '{'{CMD_READ, 8'hFF, 7'd2, 5'd0}, 1, 1'b1, '{7'd3, 5'd0, 8'hFF, 16'h07FF, 1'b0}},
        '{'{CMD_PUT, CH_CR, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_PUT, CH_NL, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd1, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_PUT, CH_BS, 7'd0, 5'd0}, 1, 1'b1, '{7'd79, 5'd0, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_PUT, 8'h5A, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd1, 8'h5A, 16'h0000, 1'b0}},
        '{'{CMD_CLR_ROW, 8'h00, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd1, 8'h5A, 16'h0000, 1'b0}},
        '{'{CMD_PUT, 8'h68, 7'd0, 5'd0}, 1, 1'b1, '{7'd1, 5'd1, 8'h68, 16'h0000, 1'b0}},
        '{'{CMD_PUT, CH_NL, 7'd0, 5'd0}, 23, 1'b0, '0},
        '{'{CMD_PUT, CH_NL, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd24, CH_SP, 16'h0000, 1'b1}},
        '{'{CMD_READ, 8'h00, 7'd0, 5'd0}, 1, 1'b0, '0},
        '{'{CMD_READ, 8'h00, 7'd79, 5'd24}, 1, 1'b0, '0},
        '{'{CMD_PUT, 8'h7E, 7'd0, 5'd0}, 1, 1'b0, '0},
        '{'{CMD_CLR_SCREEN, 8'h00, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, 16'h0000, 1'b0}},
        '{'{CMD_READ, 8'h00, 7'd0, 5'd0}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, RESET_CELL, 1'b0}},
        '{'{CMD_READ, 8'h00, 7'd79, 5'd24}, 1, 1'b1, '{7'd0, 5'd0, CH_SP, RESET_CELL, 1'b0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;

    tcce_in_if  in_bus ();
    tcce_out_if out_bus ();

    text_console_cursor_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [CELL_W-1:0] shadow_screen [CELLS];
    int                shadow_col;
    int                shadow_row;
    logic [7:0]        shadow_attr;

    console_view_t awaited_views [$];
    int            error_count;
    int            cmds_issued;
    int            reads_issued;
    int            views_checked;
    int            scrolls_seen;
    int            cycle_count;
    logic [7:0]    last_color;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void blank_row(input int row);
        for (int x = 0; x < COLS; x++) begin
            shadow_screen[row * COLS + x] = {shadow_attr, CH_SP};
        end
    endfunction

    function automatic console_view_t apply_console_cmd(input console_cmd_t c);
        console_view_t v;
        logic          may_scroll;
        v = '0;
        may_scroll = 1'b1;
        case (c.cmd)
            CMD_PUT: begin
                if (c.ch == CH_NL) begin
                    shadow_row++;
                    shadow_col = 0;
                end else if (c.ch == CH_CR) begin
                    shadow_col = 0;
                end else if (c.ch == CH_BS) begin
                    if (shadow_col > 0) begin
                        shadow_col--;
                    end else if (shadow_row > 0) begin
                        shadow_row--;
                        shadow_col = COLS - 1;
                    end
                    shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, CH_SP};
                    may_scroll = 1'b0;
                end else begin
                    shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, c.ch};
                    shadow_col++;
                    if (shadow_col == COLS) begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                end
                if (may_scroll && shadow_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
                        shadow_screen[i] = shadow_screen[i + COLS];
                    end
                    blank_row(ROWS - 1);
                    shadow_row = ROWS - 1;
                    v.scrolled = 1'b1;
                end
            end
            CMD_CLR_SCREEN: begin
                for (int r = 0; r < ROWS; r++) begin
                    blank_row(r);
                end
                shadow_col = 0;
                shadow_row = 0;
            end
            CMD_CLR_ROW: begin
                blank_row(shadow_row);
                shadow_col = 0;
            end
            CMD_READ: begin
                if (c.col < COLS && c.row < ROWS) begin
                    v.cell_word = shadow_screen[int'(c.row) * COLS + int'(c.col)];
                end
            end
        endcase
        v.col = COL_W'(shadow_col);
        v.row = ROW_W'(shadow_row);
        if (shadow_col == 0) begin
            if (shadow_row == 0) begin
                v.prev = CH_SP;
            end else begin
                v.prev = shadow_screen[(shadow_row - 1) * COLS + COLS - 1][7:0];
            end
        end else begin
            v.prev = shadow_screen[shadow_row * COLS + shadow_col - 1][7:0];
        end
        return v;
    endfunction

    function automatic console_cmd_t random_console_cmd();
        console_cmd_t c;
        int           pick;
        int           sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        c.col = COL_W'($urandom_range(0, 127));
        c.row = ROW_W'($urandom_range(0, 31));
        c.ch  = CHAR_W'($urandom_range(0, 255));
        if (pick < 85) begin
            c.cmd = CMD_PUT;
            if (sel < 52) begin
                c.ch = CHAR_W'($urandom_range(32, 126));
            end else if (sel < 62) begin
                c.ch = CHAR_W'($urandom_range(0, 255));
            end else if (sel < 82) begin
                c.ch = CH_NL;
            end else if (sel < 89) begin
                c.ch = CH_CR;
            end else begin
                c.ch = CH_BS;
            end
        end else if (pick < 86) begin
            c.cmd = CMD_CLR_SCREEN;
        end else if (pick < 90) begin
            c.cmd = CMD_CLR_ROW;
        end else begin
            c.cmd = CMD_READ;
            if (sel < 80) begin
                c.col = COL_W'($urandom_range(0, COLS - 1));
                c.row = ROW_W'($urandom_range(0, ROWS - 1));
            end
        end
        return c;
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
            error_count++;
        end
    endfunction

    task automatic send_cmd(input console_cmd_t c, input int gap, input logic typed,
                            input console_view_t want);
        console_view_t predicted;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.cmd       <= c.cmd;
        in_bus.char_code <= c.ch;
        in_bus.read_col  <= c.col;
        in_bus.read_row  <= c.row;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        predicted = apply_console_cmd(c);
        awaited_views.push_back(typed ? want : predicted);
        cmds_issued++;
        if (c.cmd == CMD_READ) begin
            reads_issued++;
        end
    endtask

    task automatic drain_results();
        in_bus.valid <= 1'b0;
        while (awaited_views.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [7:0] color);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= color;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_attr = color;
        last_color  = color;
    endtask

    task automatic random_phase(input int count);
        int gap;
        for (int k = 0; k < count; k++) begin
            gap = (k % 100 < 20) ? 0 : $urandom_range(0, 7);
            send_cmd(random_console_cmd(), gap, 1'b0, '0);
        end
    endtask

    initial begin
        console_view_t got;
        console_view_t want;
        int            stall;
        out_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (views_checked == 150) begin
                stall = LONG_HOLD;
            end else if (views_checked % 100 >= 50 && views_checked % 100 < 70) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
            got = '{out_bus.cursor_col, out_bus.cursor_row, out_bus.prev_char,
                    out_bus.cell_value, out_bus.scrolled};
            if (awaited_views.size() == 0) begin
                $display("%0t: unexpected result, expected none got %0h", $time, got);
                error_count++;
            end else begin
                want = awaited_views.pop_front();
                check_field("cursor_col", 16'(want.col), 16'(got.col));
                check_field("cursor_row", 16'(want.row), 16'(got.row));
                check_field("prev_char", 16'(want.prev), 16'(got.prev));
                check_field("cell_value", want.cell_word, got.cell_word);
                check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
            end
            if (got.scrolled === 1'b1) begin
                scrolls_seen++;
            end
            views_checked++;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_views.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 8'h00;
        in_bus.valid     = 1'b0;
        in_bus.cmd       = CMD_PUT;
        in_bus.char_code = 8'h00;
        in_bus.read_col  = 7'd0;
        in_bus.read_row  = 5'd0;
        error_count      = 0;
        cmds_issued      = 0;
        reads_issued     = 0;
        views_checked    = 0;
        scrolls_seen     = 0;
        shadow_col       = 0;
        shadow_row       = 0;
        shadow_attr      = RESET_COLOR;
        last_color       = RESET_COLOR;
        for (int i = 0; i < CELLS; i++) begin
            shadow_screen[i] = RESET_CELL;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCRIPT[n]) begin
            for (int r = 0; r < SCRIPT[n].reps; r++) begin
                send_cmd(SCRIPT[n].op, $urandom_range(0, 7), SCRIPT[n].typed, SCRIPT[n].want);
            end
        end
        drain_results();

        write_color(8'hFF);
        random_phase(130);
        drain_results();

        write_color(8'h00);
        random_phase(130);
        drain_results();

        write_color(8'($urandom_range(1, 254)));
        random_phase(140);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d commands issued (%0d reads), %0d results checked, %0d scrolls seen",
                 cmds_issued, reads_issued, views_checked, scrolls_seen);
        $display("colors 07, ff, 00 and %02h used; output held off %0d cycles once",
                 last_color, LONG_HOLD);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tcce_pkg.sv
design/tcce_if.sv
design/tcce_front.sv
design/tcce_queue.sv
design/tcce_back.sv
design/text_console_cursor_engine_unit.sv
test/tb_text_console_cursor_engine_unit.sv
